// File: rtl/core/lpcsyn_pkg.sv
// lpcsyn_pkg: shared types and constants of the all-pole synthesis filter.
// No dependencies; used by lpcsyn_mac, the top level and the checker.
package lpcsyn_pkg;

	localparam int ORDER_W   = 6;
	localparam int COEF_W    = 24;
	localparam int SAMPLE_W  = 16;
	localparam int FRAC_BITS = 18;
	localparam int SAT_SPAN  = 32768;

	localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd20;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_FILTER = 1'b1;

	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic clear;
		logic mul_en;
	} mac_ctl_t;

	typedef struct packed {
		logic busy;
	} mac_sts_t;

endpackage

// File: rtl/core/lpcsyn_ram.sv
// lpcsyn_ram: single-write, single-read store with registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on nothing.
module lpcsyn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rdata_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvld_q <= valid_q[raddr];
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

// File: rtl/core/lpcsyn_mac.sv
// lpcsyn_mac: shared multiply-accumulate unit with rounding and saturation.
// Depends on lpcsyn_pkg; driven by the sequencer in the top level.
module lpcsyn_mac #(
	parameter int MAX_ORDER = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lpcsyn_pkg::mac_ctl_t ctl,
	input  lpcsyn_pkg::sample_t  residual,
	input  lpcsyn_pkg::coef_t    coef,
	input  lpcsyn_pkg::sample_t  hist,
	output lpcsyn_pkg::sample_t  y,
	output logic                 sat,
	output lpcsyn_pkg::mac_sts_t sts
);

	localparam int PROD_W = lpcsyn_pkg::COEF_W + lpcsyn_pkg::SAMPLE_W;
	localparam int ACC_W  = PROD_W + $clog2(MAX_ORDER + 1) + 1;
	localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) << (lpcsyn_pkg::FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(lpcsyn_pkg::SAT_SPAN - 1);
	localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(-lpcsyn_pkg::SAT_SPAN);

	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rnd_c;
	logic signed [ACC_W-1:0]  yfull_c;

	assign prod_c = coef * hist;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_c;
		if (ctl.clear) begin
			acc_q <= ACC_W'(residual) <<< lpcsyn_pkg::FRAC_BITS;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign rnd_c   = acc_q + HALF;
	assign yfull_c = rnd_c >>> lpcsyn_pkg::FRAC_BITS;

	always_comb begin
		y   = yfull_c[lpcsyn_pkg::SAMPLE_W-1:0];
		sat = 1'b0;
		priority if (yfull_c > Y_MAX) begin
			y   = Y_MAX[lpcsyn_pkg::SAMPLE_W-1:0];
			sat = 1'b1;
		end else if (yfull_c < Y_MIN) begin
			y   = Y_MIN[lpcsyn_pkg::SAMPLE_W-1:0];
			sat = 1'b1;
		end
	end

	assign sts.busy = vld_s2;

endmodule

// File: rtl/core/lpc_all_pole_synthesis_filter.sv
// Direct-form all-pole synthesis filter. A load request (operation 0) writes one
// Q5.18 tap coefficient and returns nothing. A filter request (operation 1)
// returns one rounded, saturated 16-bit sample: one multiply-accumulate per tap
// through a single shared multiplier fed by the coefficient and history memories,
// then the read, product and accumulate pipeline drains, and the sum is rounded,
// saturated and written to the history and the result register. The input is not
// ready while a filter request is in progress; one finished result may wait in the
// output register while the next request is taken. The order register is written
// through its own channel, which is always ready.
// Depends on lpcsyn_pkg, lpcsyn_ram and lpcsyn_mac.
module lpc_all_pole_synthesis_filter #(
	parameter int MAX_ORDER = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  order_in_use,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [5:0]  coef_index,
	input  logic signed [23:0] coef_value,
	input  logic signed [15:0] residual_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] sample_out,
	output logic        saturated
);

	localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int CW = $clog2(MAX_ORDER + 1);
	localparam logic [lpcsyn_pkg::ORDER_W:0] MAX_EXT = (lpcsyn_pkg::ORDER_W + 1)'(MAX_ORDER);
	localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_ORDER - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]                       state_q;
	logic [lpcsyn_pkg::ORDER_W-1:0]   order_q;
	logic [CW-1:0]                    taps_q;
	logic [CW-1:0]                    taps_c;
	logic [CW-1:0]                    cnt_q;
	logic [CW-1:0]                    cnt_inc;
	logic [AW-1:0]                    slot_q;
	logic [AW-1:0]                    ptr_q;
	logic [AW-1:0]                    ptr_nxt;
	logic                             rd_s1;
	logic                             issue;
	logic                             in_fire;
	logic                             load_we;
	logic                             fin_fire;
	logic [lpcsyn_pkg::ORDER_W-1:0]   idx_m1;
	logic                             out_valid_q;
	lpcsyn_pkg::sample_t              sample_q;
	logic                             sat_q;
	lpcsyn_pkg::coef_t                coef_rd;
	lpcsyn_pkg::sample_t              hist_rd;
	lpcsyn_pkg::sample_t              y_c;
	logic                             sat_c;
	lpcsyn_pkg::mac_ctl_t             mac_ctl;
	lpcsyn_pkg::mac_sts_t             mac_sts;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign idx_m1    = coef_index - 6'd1;
	assign load_we   = in_fire && (operation == lpcsyn_pkg::OP_LOAD) &&
	                   (coef_index != '0) && ({1'b0, coef_index} <= MAX_EXT);
	assign issue     = (state_q == ST_RUN);
	assign cnt_inc   = cnt_q + CW'(1);
	assign fin_fire  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign ptr_nxt   = (ptr_q == LAST_SLOT) ? '0 : ptr_q + AW'(1);

	always_comb begin
		if ({1'b0, order_q} > MAX_EXT) begin
			taps_c = CW'(MAX_ORDER);
		end else begin
			taps_c = CW'(order_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= lpcsyn_pkg::ORDER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			order_q <= order_in_use;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			taps_q      <= '0;
			cnt_q       <= '0;
			slot_q      <= '0;
			ptr_q       <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && (operation == lpcsyn_pkg::OP_FILTER)) begin
						taps_q  <= taps_c;
						cnt_q   <= '0;
						slot_q  <= ptr_q;
						state_q <= (taps_c != '0) ? ST_RUN : ST_DRAIN;
					end
				end
				ST_RUN: begin
					cnt_q  <= cnt_inc;
					slot_q <= (slot_q == '0) ? LAST_SLOT : slot_q - AW'(1);
					if (cnt_inc == taps_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_s1 && !mac_sts.busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						ptr_q   <= ptr_nxt;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			sample_q <= y_c;
			sat_q    <= sat_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;
	assign saturated  = sat_q;

	assign mac_ctl.clear  = in_fire && (operation == lpcsyn_pkg::OP_FILTER);
	assign mac_ctl.mul_en = rd_s1;

	lpcsyn_ram #(
		.WIDTH (lpcsyn_pkg::COEF_W),
		.DEPTH (MAX_ORDER)
	) u_coef_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (load_we),
		.waddr  (idx_m1[AW-1:0]),
		.wdata  (coef_value),
		.raddr  (cnt_q[AW-1:0]),
		.rdata  (coef_rd)
	);

	lpcsyn_ram #(
		.WIDTH (lpcsyn_pkg::SAMPLE_W),
		.DEPTH (MAX_ORDER)
	) u_hist_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (fin_fire),
		.waddr  (ptr_nxt),
		.wdata  (y_c),
		.raddr  (slot_q),
		.rdata  (hist_rd)
	);

	lpcsyn_mac #(
		.MAX_ORDER (MAX_ORDER)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.residual (residual_in),
		.coef     (coef_rd),
		.hist     (hist_rd),
		.y        (y_c),
		.sat      (sat_c),
		.sts      (mac_sts)
	);

endmodule

// File: rtl/core/lpcsyn_chk.sv
// lpcsyn_chk: port-level checks on the synthesis filter, bound to the top level.
// Depends on lpcsyn_pkg and lpc_all_pole_synthesis_filter.
module lpcsyn_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        operation,
	input logic        out_valid,
	input logic        out_ready,
	input logic signed [15:0] sample_out,
	input logic        saturated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(saturated))
		else $error("result changed while stalled");

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> sample_out == 16'sh7fff || sample_out == -16'sh8000)
		else $error("saturated flag without a clipped sample");

	a_filter_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == lpcsyn_pkg::OP_FILTER |=> !in_ready)
		else $error("input ready right after a filter request");

	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == lpcsyn_pkg::OP_LOAD |=> in_ready)
		else $error("load request stalled the input");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a filter request in progress");

endmodule

bind lpc_all_pole_synthesis_filter lpcsyn_chk u_lpcsyn_chk (.*);
